@@ rtl/f16fc_pkg.sv @@
// Shared types, constants and helpers of the Fletcher-16 frame checker.
package f16fc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [ByteW:0] ModBase = 9'd255;

  // Front-end sequencer phases, one-hot.
  typedef enum logic [3:0] {
    PH_LEN   = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_CK_HI = 4'b0100,
    PH_CK_LO = 4'b1000
  } phase_e;

  // What the back end has to emit for one queued command.
  typedef enum logic [1:0] {
    CMD_GEN   = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_LERR  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    logic             ok;
  } cmd_t;

  // Queue handshake between front end and queue.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  // Fold a sum of two mod-255 operands back into range.
  function automatic logic [ByteW-1:0] fold255(input logic [ByteW:0] t);
    logic [ByteW:0] r;
    r = (t >= ModBase) ? (t - ModBase) : t;
    return r[ByteW-1:0];
  endfunction

endpackage

@@ rtl/f16fc_front.sv @@
// Front end: frame sequencer, Fletcher-16 running sums and command issue.
module f16fc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       func_i,
  input  logic [f16fc_pkg::ByteW-1:0] byte_i,
  input  logic                       q_full_i,
  output logic                       in_ready_o,
  output f16fc_pkg::push_t           push_o
);

  f16fc_pkg::phase_e             phase_q, phase_d;
  logic [f16fc_pkg::ByteW-1:0]   rem_q, rem_d;
  logic [f16fc_pkg::ByteW-1:0]   slo_q, slo_d;
  logic [f16fc_pkg::ByteW-1:0]   shi_q, shi_d;
  logic                          gen_q, gen_d;
  logic                          hm_q, hm_d;
  logic                          acc;
  logic [f16fc_pkg::ByteW-1:0]   base_lo, base_hi, s1, s2, rem_nx;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;

  // A length byte restarts both sums from zero.
  assign base_lo = (phase_q == f16fc_pkg::PH_LEN) ? '0 : slo_q;
  assign base_hi = (phase_q == f16fc_pkg::PH_LEN) ? '0 : shi_q;
  assign s1 = f16fc_pkg::fold255({1'b0, base_lo} + {1'b0, byte_i});
  assign s2 = f16fc_pkg::fold255({1'b0, base_hi} + {1'b0, s1});
  assign rem_nx = ((phase_q == f16fc_pkg::PH_LEN) ? byte_i : rem_q) - 8'd1;

  always_comb begin
    phase_d          = phase_q;
    rem_d            = rem_q;
    slo_d            = slo_q;
    shi_d            = shi_q;
    gen_d            = gen_q;
    hm_d             = hm_q;
    push_o.push      = 1'b0;
    push_o.cmd.kind  = f16fc_pkg::CMD_LERR;
    push_o.cmd.hi    = s2;
    push_o.cmd.lo    = s1;
    push_o.cmd.ok    = 1'b0;
    if (acc) begin
      unique case (phase_q)
        f16fc_pkg::PH_LEN: begin
          if (byte_i == '0) begin
            push_o.push     = 1'b1;
            push_o.cmd.kind = f16fc_pkg::CMD_LERR;
          end else begin
            gen_d = func_i;
            hm_d  = 1'b0;
            slo_d = s1;
            shi_d = s2;
            rem_d = rem_nx;
            if (rem_nx == '0) begin
              if (func_i) begin
                push_o.push     = 1'b1;
                push_o.cmd.kind = f16fc_pkg::CMD_GEN;
                phase_d         = f16fc_pkg::PH_LEN;
              end else begin
                phase_d = f16fc_pkg::PH_CK_HI;
              end
            end else begin
              phase_d = f16fc_pkg::PH_DATA;
            end
          end
        end
        f16fc_pkg::PH_DATA: begin
          slo_d = s1;
          shi_d = s2;
          rem_d = rem_nx;
          if (rem_nx == '0) begin
            if (gen_q) begin
              push_o.push     = 1'b1;
              push_o.cmd.kind = f16fc_pkg::CMD_GEN;
              phase_d         = f16fc_pkg::PH_LEN;
            end else begin
              phase_d = f16fc_pkg::PH_CK_HI;
            end
          end
        end
        f16fc_pkg::PH_CK_HI: begin
          hm_d    = (byte_i == shi_q);
          phase_d = f16fc_pkg::PH_CK_LO;
        end
        f16fc_pkg::PH_CK_LO: begin
          push_o.push     = 1'b1;
          push_o.cmd.kind = f16fc_pkg::CMD_CHECK;
          push_o.cmd.ok   = hm_q && (byte_i == slo_q);
          phase_d         = f16fc_pkg::PH_LEN;
        end
        default: phase_d = f16fc_pkg::PH_LEN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= f16fc_pkg::PH_LEN;
      rem_q   <= '0;
      slo_q   <= '0;
      shi_q   <= '0;
      gen_q   <= 1'b0;
      hm_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      slo_q   <= slo_d;
      shi_q   <= shi_d;
      gen_q   <= gen_d;
      hm_q    <= hm_d;
    end
  end

  a_data_has_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == f16fc_pkg::PH_DATA |-> rem_q != '0)
    else $error("data phase with no covered bytes left");

  a_sums_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slo_q != 8'hFF && shi_q != 8'hFF)
    else $error("running sum left mod-255 range");

endmodule

@@ rtl/f16fc_queue.sv @@
// Short command queue between front end and back end.
module f16fc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  f16fc_pkg::push_t  push_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output f16fc_pkg::cmd_t   cmd_o
);

  f16fc_pkg::cmd_t              mem_q [f16fc_pkg::QDepth];
  logic [f16fc_pkg::QAw-1:0]    wr_q, rd_q;
  logic [f16fc_pkg::QAw:0]      cnt_q;
  logic                         wr_en, rd_en;

  assign full_o  = (cnt_q == (f16fc_pkg::QAw+1)'(f16fc_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i.push && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (f16fc_pkg::QAw+1)'(wr_en) - (f16fc_pkg::QAw+1)'(rd_en);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (f16fc_pkg::QAw+1)'(f16fc_pkg::QDepth))
    else $error("queue fill beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i.push)
    else $error("command pushed into full queue");

endmodule

@@ rtl/f16fc_back.sv @@
// Back end: expands queued commands into result words in an output register.
module f16fc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  f16fc_pkg::cmd_t             cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [f16fc_pkg::ByteW-1:0] out_byte_o,
  output logic                        check_ok_o,
  output logic                        length_error_o,
  output logic                        last_o
);

  logic                        vld_q, vld_d;
  logic                        pend_q, pend_d;
  logic [f16fc_pkg::ByteW-1:0] lo_q, lo_d;
  logic [f16fc_pkg::ByteW-1:0] ob_q, ob_d;
  logic                        ok_q, ok_d, le_q, le_d, lst_q, lst_d;
  logic                        free;

  assign free  = !vld_q || out_ready_i;
  assign pop_o = free && !pend_q && !q_empty_i;

  always_comb begin
    vld_d  = vld_q;
    pend_d = pend_q;
    lo_d   = lo_q;
    ob_d   = ob_q;
    ok_d   = ok_q;
    le_d   = le_q;
    lst_d  = lst_q;
    if (free) begin
      vld_d = 1'b0;
      if (pend_q) begin
        // Second word of a generated checksum: low byte.
        vld_d  = 1'b1;
        pend_d = 1'b0;
        ob_d   = lo_q;
        ok_d   = 1'b0;
        le_d   = 1'b0;
        lst_d  = 1'b1;
      end else if (!q_empty_i) begin
        vld_d = 1'b1;
        unique case (cmd_i.kind)
          f16fc_pkg::CMD_GEN: begin
            pend_d = 1'b1;
            lo_d   = cmd_i.lo;
            ob_d   = cmd_i.hi;
            ok_d   = 1'b0;
            le_d   = 1'b0;
            lst_d  = 1'b0;
          end
          f16fc_pkg::CMD_CHECK: begin
            ob_d  = '0;
            ok_d  = cmd_i.ok;
            le_d  = 1'b0;
            lst_d = 1'b1;
          end
          default: begin
            ob_d  = '0;
            ok_d  = 1'b0;
            le_d  = 1'b1;
            lst_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    ob_q  <= ob_d;
    ok_q  <= ok_d;
    le_q  <= le_d;
    lst_q <= lst_d;
  end

  assign out_valid_o    = vld_q;
  assign out_byte_o     = ob_q;
  assign check_ok_o     = ok_q;
  assign length_error_o = le_q;
  assign last_o         = lst_q;

  a_pend_high_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> vld_q && !lst_q)
    else $error("low byte pending without high byte on output");

  a_no_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !pop_o)
    else $error("queue popped while low byte still pending");

endmodule

@@ rtl/fletcher16_frame_checker_top.sv @@
// A result command is queued as its closing byte is accepted, then loads the output register.
// The low byte of a generated checksum follows once the high byte is taken.
// Throughput: one input byte per cycle unless the queue is full; one result word per cycle unless stalled.
// A generated checksum gives two words from one command; a four-entry queue
// between the front sequencer and the output register absorbs the burst.
// Reset (rst_ni low, asynchronous) empties the queue and output and awaits a length byte.
// Top level of the Fletcher-16 frame checker and generator.
module fletcher16_frame_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic [0:0] s_axis_tuser_i,  // [0] func
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,  // [0] check_ok, [1] length_error
  output logic       m_axis_tlast_o
);

  f16fc_pkg::push_t push;
  f16fc_pkg::cmd_t  q_cmd;
  logic             q_full, q_empty, q_pop;

  f16fc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .func_i     (s_axis_tuser_i[0]),
    .byte_i     (s_axis_tdata_i),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push)
  );

  f16fc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  f16fc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .cmd_i          (q_cmd),
    .pop_o          (q_pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_byte_o     (m_axis_tdata_o),
    .check_ok_o     (m_axis_tuser_o[0]),
    .length_error_o (m_axis_tuser_o[1]),
    .last_o         (m_axis_tlast_o)
  );

endmodule

@@ bench/testbench.sv @@
// Stream testbench for the Fletcher-16 frame checker: framed byte stimulus, predictor, monitor.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic                        func;
    logic [f16fc_pkg::ByteW-1:0] data;
  } in_byte_t;

  typedef struct packed {
    logic [f16fc_pkg::ByteW-1:0] out_byte;
    logic                        check_ok;
    logic                        length_error;
    logic                        last;
  } word_t;

  // How the trailing checksum of a check-mode frame is built.
  typedef enum logic [1:0] {
    TR_GOOD,
    TR_BAD_HI,
    TR_BAD_LO,
    TR_BAD_BOTH
  } trail_e;

  typedef enum logic [1:0] {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;
  logic [0:0] s_axis_tuser_i  = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic       m_axis_tlast_o;

  fletcher16_frame_checker_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  in_byte_t in_bytes_q[$];
  word_t    due_words_q[$];
  int       mismatches = 0;

  // Predictor state.
  f16fc_pkg::phase_e           trk_phase  = f16fc_pkg::PH_LEN;
  logic [f16fc_pkg::ByteW-1:0] trk_left   = '0;
  logic [f16fc_pkg::ByteW-1:0] trk_s1     = '0;
  logic [f16fc_pkg::ByteW-1:0] trk_s2     = '0;
  logic                        trk_gen    = 1'b0;
  logic                        trk_hi_ok  = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [f16fc_pkg::ByteW-1:0] add255(logic [f16fc_pkg::ByteW-1:0] a,
                                                          logic [f16fc_pkg::ByteW-1:0] b);
    int t;
    t = (int'(a) + int'(b)) % 255;
    return 8'(t);
  endfunction

  // Covered bytes done: queue the checksum or wait for the trailer.
  function automatic void close_cover();
    if (trk_gen) begin
      due_words_q.push_back('{out_byte: trk_s2, check_ok: 1'b0, length_error: 1'b0,
                              last: 1'b0});
      due_words_q.push_back('{out_byte: trk_s1, check_ok: 1'b0, length_error: 1'b0,
                              last: 1'b1});
      trk_phase = f16fc_pkg::PH_LEN;
    end else begin
      trk_phase = f16fc_pkg::PH_CK_HI;
    end
  endfunction

  function automatic void fletcher_track(in_byte_t ib);
    case (trk_phase)
      f16fc_pkg::PH_LEN: begin
        if (ib.data == '0) begin
          due_words_q.push_back('{out_byte: 8'h00, check_ok: 1'b0, length_error: 1'b1,
                                  last: 1'b1});
        end else begin
          trk_gen   = ib.func;
          trk_hi_ok = 1'b0;
          trk_s1    = add255(8'h00, ib.data);
          trk_s2    = trk_s1;
          trk_left  = ib.data - 8'd1;
          if (trk_left == '0) close_cover();
          else trk_phase = f16fc_pkg::PH_DATA;
        end
      end
      f16fc_pkg::PH_DATA: begin
        trk_s1   = add255(trk_s1, ib.data);
        trk_s2   = add255(trk_s2, trk_s1);
        trk_left = trk_left - 8'd1;
        if (trk_left == '0) close_cover();
      end
      f16fc_pkg::PH_CK_HI: begin
        trk_hi_ok = (ib.data == trk_s2);
        trk_phase = f16fc_pkg::PH_CK_LO;
      end
      f16fc_pkg::PH_CK_LO: begin
        due_words_q.push_back('{out_byte: 8'h00, check_ok: trk_hi_ok && (ib.data == trk_s1),
                                length_error: 1'b0, last: 1'b1});
        trk_phase = f16fc_pkg::PH_LEN;
      end
      default: trk_phase = f16fc_pkg::PH_LEN;
    endcase
  endfunction

  // Append one whole frame; func on non-length bytes is random and ignored.
  function automatic void add_frame(logic gen, logic [f16fc_pkg::ByteW-1:0] len,
                                    trail_e trail, fill_e fill);
    logic [f16fc_pkg::ByteW-1:0] s1;
    logic [f16fc_pkg::ByteW-1:0] s2;
    logic [f16fc_pkg::ByteW-1:0] b;
    logic [f16fc_pkg::ByteW-1:0] hi;
    logic [f16fc_pkg::ByteW-1:0] lo;
    int                          i;
    in_bytes_q.push_back('{func: gen, data: len});
    if (len == '0) return;
    s1 = add255(8'h00, len);
    s2 = s1;
    for (i = 1; i < int'(len); i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      in_bytes_q.push_back('{func: 1'($urandom_range(0, 1)), data: b});
      s1 = add255(s1, b);
      s2 = add255(s2, s1);
    end
    if (!gen) begin
      hi = s2;
      lo = s1;
      if (trail == TR_BAD_HI || trail == TR_BAD_BOTH) hi = hi ^ (8'h01 << $urandom_range(0, 7));
      if (trail == TR_BAD_LO || trail == TR_BAD_BOTH) lo = lo ^ (8'h01 << $urandom_range(0, 7));
      in_bytes_q.push_back('{func: 1'($urandom_range(0, 1)), data: hi});
      in_bytes_q.push_back('{func: 1'($urandom_range(0, 1)), data: lo});
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 8;
  int gap_left   = 0;

  always @(posedge clk_i) begin : drive
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        fletcher_track(in_bytes_q[0]);
        void'(in_bytes_q.pop_front());
      end
      // Hold the word until it is taken.
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (in_bytes_q.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= in_bytes_q[0].data;
          s_axis_tuser_i  <= in_bytes_q[0].func;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a tick counter periodically redraws the stall mode from four patterns.
  int rx_tick = 0;
  int rx_mode = 0;

  always @(posedge clk_i) begin : watch
    word_t got;
    word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{out_byte: m_axis_tdata_o, check_ok: m_axis_tuser_o[0],
                length_error: m_axis_tuser_o[1], last: m_axis_tlast_o};
        if (due_words_q.size() == 0) begin
          $error("unexpected result word: out_byte %0h", got.out_byte);
          mismatches++;
        end else begin
          want = due_words_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            mismatches++;
          end
          if (got.check_ok !== want.check_ok) begin
            $error("check_ok: expected %0b, got %0b", want.check_ok, got.check_ok);
            mismatches++;
          end
          if (got.length_error !== want.length_error) begin
            $error("length_error: expected %0b, got %0b", want.length_error,
                   got.length_error);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
          end
        end
      end
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
        2:       m_axis_tready_i <= (rx_tick % 4 == 0);
        default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : stimulus
    int          r;
    int          big_cnt;
    int          t;
    logic [7:0]  len;
    trail_e      trail;
    big_cnt = 0;
    // Directed: zero length in both modes, length one, extreme fills, each trailer fault.
    add_frame(1'b0, 8'd0, TR_GOOD, FILL_RAND);
    add_frame(1'b1, 8'd0, TR_GOOD, FILL_RAND);
    add_frame(1'b1, 8'd1, TR_GOOD, FILL_RAND);
    add_frame(1'b0, 8'd1, TR_GOOD, FILL_RAND);
    add_frame(1'b0, 8'd1, TR_BAD_HI, FILL_RAND);
    add_frame(1'b1, 8'd2, TR_GOOD, FILL_ONES);
    add_frame(1'b0, 8'd3, TR_GOOD, FILL_ZERO);
    add_frame(1'b0, 8'd3, TR_BAD_LO, FILL_ONES);
    add_frame(1'b0, 8'd2, TR_BAD_BOTH, FILL_RAND);
    // Random frames, mostly short, with at most two long ones, the first of full length.
    while (in_bytes_q.size() < 645) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        len = 8'd0;
      end else if (r < 11 && big_cnt < 2) begin
        len = (big_cnt == 0) ? 8'd255 : 8'($urandom_range(200, 254));
        big_cnt++;
      end else begin
        len = 8'($urandom_range(1, 12));
      end
      t = $urandom_range(0, 5);
      trail = (t < 3) ? TR_GOOD : trail_e'(t - 2);
      add_frame(1'($urandom_range(0, 1)), len, trail,
                ($urandom_range(0, 9) == 0) ? fill_e'($urandom_range(1, 2)) : FILL_RAND);
    end
    wait (rst_ni);
    while (in_bytes_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (due_words_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("testbench failed");
    $finish;
  end

endmodule
